// ----- hw/rtl/emwt_pkg.sv -----
// ----------------------------------------------------------------------------
// emwt_pkg
// Shared widths, register indexes and reset values for the epoch minimum
// watermark trigger.
// ----------------------------------------------------------------------------
package emwt_pkg;

	localparam int EPOCH_W      = 16;
	localparam int RATIO_W      = 10;
	localparam int LEVEL_W      = 48;
	localparam int CFG_INDEX_W  = 3;

	localparam int DEF_SAMPLE_WIDTH    = 48;
	localparam int DEF_RATIO_FRAC_BITS = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EPOCH_LENGTH  = 3'd0,
		REG_COLLECT_RATIO = 3'd1,
		REG_EAGER_RATIO   = 3'd2,
		REG_NOTIFY_RATIO  = 3'd3,
		REG_INITIAL_LEVEL = 3'd4
	} cfg_reg_t;

	localparam logic [EPOCH_W-1:0] RST_EPOCH_LENGTH  = 16'd10;
	localparam logic [RATIO_W-1:0] RST_RATIO         = 10'd256;
	localparam logic [LEVEL_W-1:0] RST_INITIAL_LEVEL = 48'd0;
	localparam logic [EPOCH_W-1:0] RST_SAMPLE_COUNT  = 16'd1;

endpackage

// ----- hw/rtl/emwt_scaled_cmp.sv -----
// ----------------------------------------------------------------------------
// emwt_scaled_cmp
// Exact test level > mark * ratio, ratio in unsigned fixed point with
// RATIO_FRAC_BITS fraction bits. No rounding: the level is shifted up instead.
// ----------------------------------------------------------------------------
module emwt_scaled_cmp #(
	parameter int SAMPLE_WIDTH    = emwt_pkg::DEF_SAMPLE_WIDTH,
	parameter int RATIO_FRAC_BITS = emwt_pkg::DEF_RATIO_FRAC_BITS
) (
	input  logic [SAMPLE_WIDTH-1:0]      level,
	input  logic [SAMPLE_WIDTH-1:0]      mark,
	input  logic [emwt_pkg::RATIO_W-1:0] ratio,
	output logic                         above
);

	localparam int CW = SAMPLE_WIDTH +
		((RATIO_FRAC_BITS > emwt_pkg::RATIO_W) ? RATIO_FRAC_BITS : emwt_pkg::RATIO_W);

	logic [CW-1:0] level_scaled;
	logic [CW-1:0] mark_scaled;

	assign level_scaled = CW'(level) << RATIO_FRAC_BITS;
	assign mark_scaled  = CW'(mark) * CW'(ratio);
	assign above        = level_scaled > mark_scaled;

endmodule

// ----- hw/rtl/epoch_min_watermark_trigger.sv -----
// ----------------------------------------------------------------------------
// epoch_min_watermark_trigger
// Tracks the minimum usage sample over an epoch and, at each epoch close,
// tests it against scaled collect and notify watermarks.
// ----------------------------------------------------------------------------
// Pipeline: each sample passes the input register, then the result register;
// state update and all three scaled compares sit in the single stage
// between them.
// Throughput: one sample per cycle; a held result stalls input only when the
// input register is also full.
// Reset: config registers return to defaults, levels to 0, counter to 1.
module epoch_min_watermark_trigger #(
	parameter int SAMPLE_WIDTH    = emwt_pkg::DEF_SAMPLE_WIDTH,
	parameter int RATIO_FRAC_BITS = emwt_pkg::DEF_RATIO_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [emwt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [emwt_pkg::LEVEL_W-1:0]     cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [SAMPLE_WIDTH-1:0]          usage_bytes,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             trigger_collect,
	output logic                             notify_reclaim,
	output logic                             epoch_closed
);

	// configuration
	logic [emwt_pkg::EPOCH_W-1:0] epoch_length_q;
	logic [emwt_pkg::RATIO_W-1:0] collect_ratio_q;
	logic [emwt_pkg::RATIO_W-1:0] eager_ratio_q;
	logic [emwt_pkg::RATIO_W-1:0] notify_ratio_q;

	// tracking state
	logic [emwt_pkg::EPOCH_W-1:0] sample_count_q;
	logic [SAMPLE_WIDTH-1:0]      epoch_low_q;
	logic [SAMPLE_WIDTH-1:0]      collect_mark_q;
	logic [SAMPLE_WIDTH-1:0]      notify_mark_q;
	logic                         notify_pending_q;

	// input stage
	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] usage_s1;

	// result register
	logic out_valid_q;
	logic trigger_q;
	logic notify_q;
	logic closed_q;

	logic                         advance;
	logic                         cfg_xfer;
	logic [63:0]                  init_wide;
	logic [SAMPLE_WIDTH-1:0]      init_level;
	logic [emwt_pkg::EPOCH_W-1:0] count_inc;
	logic                         close;
	logic                         above_collect;
	logic                         above_eager;
	logic                         above_notify;
	logic                         do_trigger;
	logic                         do_notify;
	logic [SAMPLE_WIDTH-1:0]      collect_next;
	logic [SAMPLE_WIDTH-1:0]      notify_next;
	logic                         pending_next;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;

	assign init_wide  = 64'(cfg_data);
	assign init_level = init_wide[SAMPLE_WIDTH-1:0];

	assign count_inc = sample_count_q + emwt_pkg::EPOCH_W'(1);
	assign close     = count_inc == epoch_length_q;

	emwt_scaled_cmp #(
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_cmp_collect (
		.level (epoch_low_q),
		.mark  (collect_mark_q),
		.ratio (collect_ratio_q),
		.above (above_collect)
	);

	emwt_scaled_cmp #(
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_cmp_eager (
		.level (epoch_low_q),
		.mark  (collect_mark_q),
		.ratio (eager_ratio_q),
		.above (above_eager)
	);

	emwt_scaled_cmp #(
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_cmp_notify (
		.level (epoch_low_q),
		.mark  (notify_mark_q),
		.ratio (notify_ratio_q),
		.above (above_notify)
	);

	// epoch close decision; marks then follow the minimum downward
	always_comb begin
		do_trigger   = above_collect & (notify_pending_q | above_eager);
		do_notify    = above_collect ? ~(notify_pending_q | above_eager) : above_notify;
		pending_next = notify_pending_q;
		if (above_collect && !do_trigger) begin
			pending_next = 1'b1;
		end else if (!above_collect && !above_notify) begin
			pending_next = 1'b0;
		end
		collect_next = do_trigger ? epoch_low_q : collect_mark_q;
		if (epoch_low_q < collect_next) begin
			collect_next = epoch_low_q;
		end
		notify_next = do_notify ? epoch_low_q : notify_mark_q;
		if (epoch_low_q < notify_next) begin
			notify_next = epoch_low_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_length_q  <= emwt_pkg::RST_EPOCH_LENGTH;
			collect_ratio_q <= emwt_pkg::RST_RATIO;
			eager_ratio_q   <= emwt_pkg::RST_RATIO;
			notify_ratio_q  <= emwt_pkg::RST_RATIO;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				emwt_pkg::REG_EPOCH_LENGTH:  epoch_length_q  <= cfg_data[emwt_pkg::EPOCH_W-1:0];
				emwt_pkg::REG_COLLECT_RATIO: collect_ratio_q <= cfg_data[emwt_pkg::RATIO_W-1:0];
				emwt_pkg::REG_EAGER_RATIO:   eager_ratio_q   <= cfg_data[emwt_pkg::RATIO_W-1:0];
				emwt_pkg::REG_NOTIFY_RATIO:  notify_ratio_q  <= cfg_data[emwt_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q   <= emwt_pkg::RST_SAMPLE_COUNT;
			epoch_low_q      <= SAMPLE_WIDTH'(emwt_pkg::RST_INITIAL_LEVEL);
			collect_mark_q   <= SAMPLE_WIDTH'(emwt_pkg::RST_INITIAL_LEVEL);
			notify_mark_q    <= SAMPLE_WIDTH'(emwt_pkg::RST_INITIAL_LEVEL);
			notify_pending_q <= 1'b0;
		end else if (cfg_xfer && cfg_index == emwt_pkg::REG_INITIAL_LEVEL) begin
			// writing the initial level restarts tracking
			sample_count_q   <= emwt_pkg::RST_SAMPLE_COUNT;
			epoch_low_q      <= init_level;
			collect_mark_q   <= init_level;
			notify_mark_q    <= init_level;
			notify_pending_q <= 1'b0;
		end else if (advance) begin
			if (close) begin
				sample_count_q   <= '0;
				epoch_low_q      <= usage_s1;
				collect_mark_q   <= collect_next;
				notify_mark_q    <= notify_next;
				notify_pending_q <= pending_next;
			end else begin
				sample_count_q <= count_inc;
				if (usage_s1 < epoch_low_q) begin
					epoch_low_q <= usage_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			usage_s1 <= usage_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trigger_q <= close & do_trigger;
			notify_q  <= close & do_notify;
			closed_q  <= close;
		end
	end

	assign out_valid       = out_valid_q;
	assign trigger_collect = trigger_q;
	assign notify_reclaim  = notify_q;
	assign epoch_closed    = closed_q;

endmodule
